### sv/aeg_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain package
// Shared constants, codes and types for the envelope gain block.
// ----------------------------------------------------------------------------
package aeg_pkg;

   // Q7.20 curve position and per-sample increment.
   localparam int FRAC_BITS = 20;
   localparam int POS_BITS  = 27;
   localparam int INC_BITS  = 27;

   // Configuration port index width and queue geometry.
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Width of the item kind field carried through the queue.
   localparam int KIND_W = 2;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_RELEASE = 2'd1,
      OP_RESTART = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK_STEPS  = 3'd0,
      CSR_DECAY_STEPS   = 3'd1,
      CSR_RELEASE_STEPS = 3'd2,
      CSR_ATTACK_INC    = 3'd3,
      CSR_DECAY_INC     = 3'd4,
      CSR_RELEASE_INC   = 3'd5
   } csr_index_type;

   localparam logic [INC_BITS-1:0] INC_RESET = 27'd16384;

   typedef struct packed {
      logic [INC_BITS-1:0] attack_inc;
      logic [INC_BITS-1:0] decay_inc;
      logic [INC_BITS-1:0] release_inc;
   } inc_cfg_type;

   typedef struct packed {
      logic can_push;
      logic has_item;
   } queue_status_type;

endpackage

### sv/aeg_channels.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain channels
// Valid/ready channel bundles for the request and response sides.
// ----------------------------------------------------------------------------
interface aeg_req_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          block_end;

   modport source (output valid, output opcode, output sample_in, output block_end,
                   input ready);
   modport sink (input valid, input opcode, input sample_in, input block_end,
                 output ready);
endinterface

interface aeg_rsp_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic [1:0]                    phase_now;
   logic                          finished;
   logic                          block_end_out;

   modport source (output valid, output sample_out, output phase_now, output finished,
                   output block_end_out, input ready);
   modport sink (input valid, input sample_out, input phase_now, input finished,
                 input block_end_out, output ready);
endinterface

### sv/aeg_front.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain front end
// Accepts request transfers, classifies the opcode and feeds the queue.
// ----------------------------------------------------------------------------
module aeg_front #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   aeg_req_if.sink                                req_chan,
   input  aeg_pkg::queue_status_type              q_status,
   output logic                                   push_valid,
   output logic [aeg_pkg::KIND_W+SAMPLE_BITS:0]   push_data
);

   localparam int ENTRY_W = aeg_pkg::KIND_W + SAMPLE_BITS + 1;

   logic               hold_valid_ff, hold_valid_in;
   logic [ENTRY_W-1:0] hold_data_ff, hold_data_in;
   logic               accept;
   logic               keep;
   aeg_pkg::kind_type  kind;

   // The unused opcode is dropped here and never reaches the queue.
   always_comb begin
      keep = 1'b1;
      kind = aeg_pkg::KIND_SAMPLE;
      case (req_chan.opcode)
         aeg_pkg::OP_SAMPLE:  kind = aeg_pkg::KIND_SAMPLE;
         aeg_pkg::OP_RELEASE: kind = aeg_pkg::KIND_RELEASE;
         aeg_pkg::OP_RESTART: kind = aeg_pkg::KIND_RESTART;
         default:             keep = 1'b0;
      endcase
   end

   assign req_chan.ready = !hold_valid_ff || q_status.can_push;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (accept) begin
         hold_valid_in = keep;
         hold_data_in  = {kind, req_chan.block_end, req_chan.sample_in};
      end else if (q_status.can_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_data_ff <= hold_data_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_data_ff;

endmodule

### sv/aeg_queue.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module aeg_queue #(
   parameter int WIDTH = 35
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output aeg_pkg::queue_status_type     q_status
);

   logic [WIDTH-1:0]                  entry_ff [aeg_pkg::QUEUE_DEPTH];
   logic [aeg_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [aeg_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [aeg_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push, do_pop;

   assign q_status.can_push = count_ff != aeg_pkg::QUEUE_CNT_W'(aeg_pkg::QUEUE_DEPTH);
   assign q_status.has_item = count_ff != '0;

   assign do_push = push_valid && q_status.can_push;
   assign do_pop  = pop && q_status.has_item;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   property p_no_overfill;
      @(posedge clock) disable iff (reset)
      count_ff <= aeg_pkg::QUEUE_CNT_W'(aeg_pkg::QUEUE_DEPTH);
   endproperty
   a_no_overfill: assert property (p_no_overfill)
      else $error("queue holds more entries than its depth");

   property p_count_tracks;
      @(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1;
   endproperty
   a_count_tracks: assert property (p_count_tracks)
      else $error("queue count did not follow a lone push");
`endif

endmodule

### sv/aeg_back.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain back end
// Holds the envelope state, resolves the phase, and scales each sample.
// ----------------------------------------------------------------------------
module aeg_back #(
   parameter int CURVE_POINTS = 64,
   parameter int STEP_BITS    = 24,
   parameter int SAMPLE_BITS  = 32,
   parameter int GAIN_SHIFT   = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  aeg_pkg::queue_status_type             q_status,
   input  logic [aeg_pkg::KIND_W+SAMPLE_BITS:0]  pop_data,
   output logic                                  pop,
   input  logic [STEP_BITS-1:0]                  attack_steps,
   input  logic [STEP_BITS-1:0]                  decay_steps,
   input  logic [STEP_BITS-1:0]                  release_steps,
   input  aeg_pkg::inc_cfg_type                  inc_cfg,
   aeg_rsp_if.source                             rsp_chan
);

   localparam int ENTRY_W = aeg_pkg::KIND_W + SAMPLE_BITS + 1;
   localparam int IDX_W   = $clog2(CURVE_POINTS);
   localparam int IP_W    = aeg_pkg::POS_BITS - aeg_pkg::FRAC_BITS;
   localparam int PROD_W  = SAMPLE_BITS + IDX_W + 1 + GAIN_SHIFT;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CURVE_POINTS - 1);

   // Envelope state.
   aeg_pkg::phase_type            phase_ff, phase_in;
   logic                          pending_ff, pending_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [aeg_pkg::POS_BITS-1:0]  pos_ff, pos_in;

   // Stage A: resolved gain factor and sample.
   logic                          a_valid_ff, a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [IDX_W-1:0]              a_factor_ff;
   logic                          a_pass_ff;
   logic                          a_zero_ff;
   aeg_pkg::phase_type            a_phase_ff;
   logic                          a_blk_ff;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   aeg_pkg::phase_type            rsp_phase_ff;
   logic                          rsp_finished_ff;
   logic                          rsp_blk_ff;

   logic                          b_adv, a_adv;
   aeg_pkg::kind_type             kind;
   logic                          blk;
   logic signed [SAMPLE_BITS-1:0] smp;

   aeg_pkg::phase_type            ph;
   logic                          fresh;
   logic [STEP_BITS-1:0]          cur_steps;
   logic [aeg_pkg::INC_BITS-1:0]  cur_inc;
   logic [STEP_BITS-1:0]          base_step;
   logic [aeg_pkg::POS_BITS-1:0]  base_pos;
   logic                          done;
   logic [aeg_pkg::POS_BITS-1:0]  pos_sum;
   logic [STEP_BITS-1:0]          step_inc;

   logic [IP_W-1:0]               ip;
   logic [31:0]                   ip_wide;
   logic [IDX_W-1:0]              idx;
   logic [IDX_W-1:0]              factor;

   logic signed [PROD_W-1:0]      sample_ext, factor_ext, prod, shifted;

   assign kind = aeg_pkg::kind_type'(pop_data[ENTRY_W-1 -: aeg_pkg::KIND_W]);
   assign blk  = pop_data[SAMPLE_BITS];
   assign smp  = pop_data[SAMPLE_BITS-1:0];

   assign b_adv = !rsp_valid_ff || rsp_chan.ready;
   assign a_adv = !a_valid_ff || b_adv;
   assign pop   = q_status.has_item && a_adv;

   // Phase resolution: phases that have run their steps are left before the
   // sample is used, so a phase with zero steps falls straight through.
   always_comb begin
      ph    = phase_ff;
      fresh = 1'b0;
      if (ph == aeg_pkg::PH_ATTACK && step_ff >= attack_steps) begin
         ph    = aeg_pkg::PH_DECAY;
         fresh = 1'b1;
      end
      if (ph == aeg_pkg::PH_DECAY &&
          (fresh ? (decay_steps == '0) : (step_ff >= decay_steps))) begin
         ph    = aeg_pkg::PH_SUSTAIN;
         fresh = 1'b1;
      end
      if (ph == aeg_pkg::PH_SUSTAIN && pending_ff) begin
         ph    = aeg_pkg::PH_RELEASE;
         fresh = 1'b1;
      end
      case (ph)
         aeg_pkg::PH_ATTACK: begin
            cur_steps = attack_steps;
            cur_inc   = inc_cfg.attack_inc;
         end
         aeg_pkg::PH_DECAY: begin
            cur_steps = decay_steps;
            cur_inc   = inc_cfg.decay_inc;
         end
         default: begin
            cur_steps = release_steps;
            cur_inc   = inc_cfg.release_inc;
         end
      endcase
      base_step = fresh ? '0 : step_ff;
      base_pos  = fresh ? '0 : pos_ff;
      done      = base_step >= cur_steps;
      pos_sum   = base_pos + cur_inc;
      step_inc  = base_step + 1'b1;
   end

   // Next envelope state.
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      step_in    = step_ff;
      pos_in     = pos_ff;
      if (pop) begin
         case (kind)
            aeg_pkg::KIND_RELEASE: pending_in = 1'b1;
            aeg_pkg::KIND_RESTART: begin
               pending_in = 1'b0;
               phase_in   = aeg_pkg::PH_ATTACK;
               step_in    = '0;
               pos_in     = '0;
            end
            aeg_pkg::KIND_SAMPLE: begin
               phase_in = ph;
               if (ph != aeg_pkg::PH_SUSTAIN && !done) begin
                  step_in = step_inc;
                  pos_in  = pos_sum;
               end else begin
                  step_in = base_step;
                  pos_in  = base_pos;
               end
            end
            default: ;
         endcase
      end
   end

   // Gain factor from the curve index, clamped to the last curve point.
   always_comb begin
      ip      = pos_sum[aeg_pkg::POS_BITS-1:aeg_pkg::FRAC_BITS];
      ip_wide = 32'(ip);
      idx     = (ip_wide > 32'(CURVE_POINTS - 1)) ? IDX_MAX : ip_wide[IDX_W-1:0];
      factor  = (ph == aeg_pkg::PH_ATTACK) ? idx : IDX_MAX - idx;
   end

   assign a_valid_in   = pop && kind == aeg_pkg::KIND_SAMPLE;
   assign rsp_valid_in = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= aeg_pkg::PH_ATTACK;
         pending_ff   <= 1'b0;
         step_ff      <= '0;
         pos_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         step_ff    <= step_in;
         pos_ff     <= pos_in;
         if (a_adv) begin
            a_valid_ff <= a_valid_in;
         end
         if (b_adv) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
      if (a_adv) begin
         a_sample_ff <= smp;
         a_factor_ff <= factor;
         a_pass_ff   <= ph == aeg_pkg::PH_SUSTAIN;
         a_zero_ff   <= ph != aeg_pkg::PH_SUSTAIN && done;
         a_phase_ff  <= ph;
         a_blk_ff    <= blk;
      end
   end

   // Full-width product, then an arithmetic shift back to sample width.
   always_comb begin
      sample_ext = PROD_W'(a_sample_ff);
      factor_ext = signed'(PROD_W'(a_factor_ff));
      prod       = sample_ext * factor_ext;
      shifted    = prod >>> GAIN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (b_adv && a_valid_ff) begin
         if (a_pass_ff) begin
            rsp_sample_ff <= a_sample_ff;
         end else if (a_zero_ff) begin
            rsp_sample_ff <= '0;
         end else begin
            rsp_sample_ff <= shifted[SAMPLE_BITS-1:0];
         end
         rsp_phase_ff    <= a_phase_ff;
         rsp_finished_ff <= a_zero_ff;
         rsp_blk_ff      <= a_blk_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_out    = rsp_sample_ff;
   assign rsp_chan.phase_now     = rsp_phase_ff;
   assign rsp_chan.finished      = rsp_finished_ff;
   assign rsp_chan.block_end_out = rsp_blk_ff;

`ifndef ASSERT_OFF
   property p_finished_is_silent;
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_finished_ff) |->
         (rsp_phase_ff == aeg_pkg::PH_RELEASE && rsp_sample_ff == '0);
   endproperty
   a_finished_is_silent: assert property (p_finished_is_silent)
      else $error("finished result not silent or not in release");

   property p_restart_clears;
      @(posedge clock) disable iff (reset)
      (pop && kind == aeg_pkg::KIND_RESTART) |=>
         (phase_ff == aeg_pkg::PH_ATTACK && step_ff == '0 && pos_ff == '0 && !pending_ff);
   endproperty
   a_restart_clears: assert property (p_restart_clears)
      else $error("restart did not return the envelope to attack");

   property p_release_latched;
      @(posedge clock) disable iff (reset)
      (pop && kind == aeg_pkg::KIND_RELEASE) |=> pending_ff;
   endproperty
   a_release_latched: assert property (p_release_latched)
      else $error("release event was not latched");

   property p_stage_a_holds;
      @(posedge clock) disable iff (reset)
      (a_valid_ff && !b_adv) |=> (a_valid_ff && $stable(a_sample_ff));
   endproperty
   a_stage_a_holds: assert property (p_stage_a_holds)
      else $error("stage A item lost while the output was stalled");
`endif

endmodule

### sv/adsr_envelope_gain.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain
// Scales an audio sample stream by an attack/decay/sustain/release envelope.
// ----------------------------------------------------------------------------
// Usage: each request transfer on req_chan carries an opcode, a sample and a
// buffer end marker. A sample opcode produces exactly one response transfer
// on rsp_chan with the scaled sample, the phase that was used, the finished
// flag and the copied end marker. Release and restart opcodes update the
// envelope state and produce no response; the unused opcode is dropped.
// A request transfer passes through the front register, the queue, the
// stage A register and the output register before the response is valid.
// Throughput is one item per cycle while the receiver keeps ready high;
// the rate is set by the phase resolution stage, which updates the step
// count and curve position for each sample, and by the single multiplier
// that follows it. Reset restores the configuration registers to their
// defaults (4096 steps and an increment of 16384 per phase), empties the
// queue, and puts the envelope into attack with no release pending.
// When the receiver stalls, the output register holds its result, the
// pipeline and the four-entry queue keep absorbing requests, and req ready
// falls only once the queue and the front register are full.
// Configuration registers are to be written through the csr port only
// while idle; the user must see to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module adsr_envelope_gain #(
   parameter int CURVE_POINTS = 64,
   parameter int STEP_BITS    = 24,
   parameter int SAMPLE_BITS  = 32,
   parameter int GAIN_SHIFT   = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   aeg_req_if.sink                            req_chan,
   aeg_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [aeg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [((STEP_BITS > aeg_pkg::INC_BITS) ? STEP_BITS : aeg_pkg::INC_BITS)-1:0]
                                              csr_write_data
);

   localparam int ENTRY_W = aeg_pkg::KIND_W + SAMPLE_BITS + 1;

   // Configuration registers.
   logic [STEP_BITS-1:0]         attack_steps_ff, attack_steps_in;
   logic [STEP_BITS-1:0]         decay_steps_ff, decay_steps_in;
   logic [STEP_BITS-1:0]         release_steps_ff, release_steps_in;
   aeg_pkg::inc_cfg_type         inc_cfg_ff, inc_cfg_in;

   // Front end to queue, and queue to back end.
   logic                         push_valid;
   logic [ENTRY_W-1:0]           push_data;
   logic                         pop;
   logic [ENTRY_W-1:0]           pop_data;
   aeg_pkg::queue_status_type    q_status;

   // Register writes land at once; writes to indexes past the last register
   // are ignored.
   always_comb begin
      attack_steps_in  = attack_steps_ff;
      decay_steps_in   = decay_steps_ff;
      release_steps_in = release_steps_ff;
      inc_cfg_in       = inc_cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            aeg_pkg::CSR_ATTACK_STEPS:  attack_steps_in  = csr_write_data[STEP_BITS-1:0];
            aeg_pkg::CSR_DECAY_STEPS:   decay_steps_in   = csr_write_data[STEP_BITS-1:0];
            aeg_pkg::CSR_RELEASE_STEPS: release_steps_in = csr_write_data[STEP_BITS-1:0];
            aeg_pkg::CSR_ATTACK_INC:
               inc_cfg_in.attack_inc  = csr_write_data[aeg_pkg::INC_BITS-1:0];
            aeg_pkg::CSR_DECAY_INC:
               inc_cfg_in.decay_inc   = csr_write_data[aeg_pkg::INC_BITS-1:0];
            aeg_pkg::CSR_RELEASE_INC:
               inc_cfg_in.release_inc = csr_write_data[aeg_pkg::INC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_steps_ff        <= STEP_BITS'(4096);
         decay_steps_ff         <= STEP_BITS'(4096);
         release_steps_ff       <= STEP_BITS'(4096);
         inc_cfg_ff.attack_inc  <= aeg_pkg::INC_RESET;
         inc_cfg_ff.decay_inc   <= aeg_pkg::INC_RESET;
         inc_cfg_ff.release_inc <= aeg_pkg::INC_RESET;
      end else begin
         attack_steps_ff  <= attack_steps_in;
         decay_steps_ff   <= decay_steps_in;
         release_steps_ff <= release_steps_in;
         inc_cfg_ff       <= inc_cfg_in;
      end
   end

   // The front end classifies each request transfer and registers it.
   aeg_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // The queue lets the front keep taking requests while the back end waits
   // on a stalled receiver.
   aeg_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .q_status   (q_status)
   );

   // The back end owns the envelope state and produces the responses.
   aeg_back #(
      .CURVE_POINTS (CURVE_POINTS),
      .STEP_BITS    (STEP_BITS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .GAIN_SHIFT   (GAIN_SHIFT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .attack_steps  (attack_steps_ff),
      .decay_steps   (decay_steps_ff),
      .release_steps (release_steps_ff),
      .inc_cfg       (inc_cfg_ff),
      .rsp_chan      (rsp_chan)
   );

endmodule
